// ===== rtl/core/bqpe_pkg.sv =====
// Package for the biquadratic patch evaluator: channel count, fraction width,
// coordinate types and the command and register codes. No dependencies.
package bqpe_pkg;
  localparam int CHANNELS = 5;
  localparam int FRAC_BITS = 16;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;
  localparam logic CFG_TILES_DOWN = 1'b0;
  localparam logic CFG_TILES_ACROSS = 1'b1;
  typedef logic signed [31:0] coord_t;
  typedef coord_t [CHANNELS-1:0] coord_vec_t;
endpackage

// ===== rtl/core/biquadratic_patch_evaluator.sv =====
// Top level of the biquadratic patch evaluator: grid store, parameter split
// and the de Casteljau pipeline. Depends on bqpe_pkg.
//
// A command transfers at a rising edge where start is high and busy is low;
// busy is held low, so one command transfers per cycle. A load writes one
// control point into the grid store and gives no result. An evaluate gives
// exactly one result, marked by done for one cycle, after it has passed the
// parameter stages, the three-tap grid read and the two pipelined quadratic
// lerp chains. The receiver cannot stall: results are never held. Loads and
// evaluates may be freely interleaved; a load is seen by any evaluate that
// transfers after it, and never by one that transferred before it. Control
// points that were never loaded read as arbitrary values. The grid store is
// nine banks (row modulo three by column modulo three) so that all nine
// points of the 3x3 patch are read together, one from each bank.
module biquadratic_patch_evaluator #(
  parameter int MAX_TILES_DOWN = 8,
  parameter int MAX_TILES_ACROSS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [4:0]  grid_row,
  input  logic [4:0]  grid_column,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] point_s,
  input  logic signed [31:0] point_t,
  input  logic [16:0] param_u,
  input  logic [16:0] param_v,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic signed [31:0] surf_x,
  output logic signed [31:0] surf_y,
  output logic signed [31:0] surf_z,
  output logic signed [31:0] surf_s,
  output logic signed [31:0] surf_t,
  output logic [16:0] sample_u,
  output logic [16:0] sample_v
);
  localparam int FRAC_BITS = bqpe_pkg::FRAC_BITS;
  localparam int GRID_ROWS = 2 * MAX_TILES_DOWN + 1;
  localparam int GRID_COLS = 2 * MAX_TILES_ACROSS + 1;
  // bank by tap index: a row r maps to tap r%3 at slot r/3
  localparam int ROW_SLOTS = (GRID_ROWS + 2) / 3;
  localparam int COL_SLOTS = (GRID_COLS + 2) / 3;
  localparam int BANK_DEPTH = ROW_SLOTS * COL_SLOTS;
  localparam int BW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int RSW = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int CSW = (COL_SLOTS > 1) ? $clog2(COL_SLOTS) : 1;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int PW = FRAC_BITS + 1;
  localparam int TW = 6;  // tile counts up to 63

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration
  logic [3:0] tiles_down, tiles_across;
  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_down <= 4'd1;
      tiles_across <= 4'd1;
    end else if (cfg_valid) begin
      if (cfg_index == bqpe_pkg::CFG_TILES_DOWN) tiles_down <= cfg_data;
      else tiles_across <= cfg_data;
    end
  end

  function automatic logic [TW-1:0] eff_tiles(input logic [3:0] r, input int maxv);
    logic [TW-1:0] v;
    v = TW'(r);
    if (r == 4'd0) v = TW'(1);
    else if (int'(r) > maxv) v = TW'(maxv);
    return v;
  endfunction

  logic [TW-1:0] eff_r, eff_c;
  assign eff_r = eff_tiles(tiles_down, MAX_TILES_DOWN);
  assign eff_c = eff_tiles(tiles_across, MAX_TILES_ACROSS);

  // x/3 by reciprocal multiplication, exact for x below 128
  function automatic logic [5:0] div3(input logic [5:0] x);
    logic [11:0] m;
    m = 12'(x) * 12'd43;
    return 6'(m >> 7);
  endfunction

  function automatic logic [1:0] mod3(input logic [5:0] x);
    logic [5:0] q;
    q = div3(x);
    return 2'(x - q * 6'd3);
  endfunction

  // Stage 0: clamp and scale parameters; decode the load address.
  bqpe_pkg::coord_vec_t pt;
  assign pt = {point_t, point_s, point_z, point_y, point_x};

  logic          s0_v, s0_load;
  logic [PW-1:0] s0_uc, s0_vc;
  logic [PW+TW-1:0] s0_su, s0_sv;
  logic [TW-1:0] s0_tc, s0_tr;
  logic [1:0]    s0_lrt, s0_lct;
  logic [RSW-1:0] s0_lrs;
  logic [CSW-1:0] s0_lcs;
  bqpe_pkg::coord_vec_t s0_pt;
  logic [PW-1:0] uc_c, vc_c;
  assign uc_c = (param_u > 17'(ONE)) ? PW'(ONE) : PW'(param_u);
  assign vc_c = (param_v > 17'(ONE)) ? PW'(ONE) : PW'(param_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s0_load <= 1'b0;
    end else begin
      s0_v <= start && action == bqpe_pkg::ACT_EVAL;
      s0_load <= start && action == bqpe_pkg::ACT_LOAD &&
                 int'(grid_row) < GRID_ROWS && int'(grid_column) < GRID_COLS;
    end
    s0_uc <= uc_c;
    s0_vc <= vc_c;
    s0_su <= (PW+TW)'(uc_c) * (PW+TW)'(eff_c);
    s0_sv <= (PW+TW)'(vc_c) * (PW+TW)'(eff_r);
    s0_tc <= eff_c;
    s0_tr <= eff_r;
    s0_lrt <= mod3({1'b0, grid_row});
    s0_lct <= mod3({1'b0, grid_column});
    s0_lrs <= RSW'(div3({1'b0, grid_row}));
    s0_lcs <= CSW'(div3({1'b0, grid_column}));
    s0_pt <= pt;
  end

  // Stage 1: tile index and local parameters.
  logic [TW-1:0] tcol_c, trow_c;
  assign tcol_c = (s0_su[PW+TW-1:FRAC_BITS] > (PW+TW-FRAC_BITS)'(s0_tc - 1'b1)) ?
                  s0_tc - 1'b1 : TW'(s0_su[PW+TW-1:FRAC_BITS]);
  assign trow_c = (s0_sv[PW+TW-1:FRAC_BITS] > (PW+TW-FRAC_BITS)'(s0_tr - 1'b1)) ?
                  s0_tr - 1'b1 : TW'(s0_sv[PW+TW-1:FRAC_BITS]);

  logic          s1_v;
  logic [PW-1:0] s1_uc, s1_vc, s1_lu, s1_lv;
  logic [TW-1:0] s1_tcol, s1_trow;
  // Hold loads back two stages so that each one writes the store at the same
  // edge offset from its transfer as an evaluate reads it: program order is
  // kept, and a read and write at one edge return the old word.
  logic          s1_load, s2_load;
  logic [1:0]    s1_lrt, s1_lct, s2_lrt, s2_lct;
  logic [BW-1:0] s1_waddr, s2_waddr;
  bqpe_pkg::coord_vec_t s1_pt, s2_pt;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s1_load <= 1'b0;
    end else begin
      s1_v <= s0_v;
      s1_load <= s0_load;
    end
    s1_uc <= s0_uc;
    s1_vc <= s0_vc;
    s1_lu <= PW'(s0_su - ((PW+TW)'(tcol_c) << FRAC_BITS));
    s1_lv <= PW'(s0_sv - ((PW+TW)'(trow_c) << FRAC_BITS));
    s1_tcol <= tcol_c;
    s1_trow <= trow_c;
    s1_lrt <= s0_lrt;
    s1_lct <= s0_lct;
    s1_waddr <= BW'(int'(s0_lrs) * COL_SLOTS + int'(s0_lcs));
    s1_pt <= s0_pt;
  end

  // Stage 2: per tap, the bank and slot that hold grid line 2*tile+tap.
  // line = 2k+j has tap (2k+j)%3; bank b holds lines with line%3==b.
  // for output tap j, the bank is (2k+j)%3 and the slot (2k+j)/3.
  logic [1:0]    rb [3];
  logic [1:0]    cb [3];
  logic [RSW-1:0] rs [3];
  logic [CSW-1:0] cs [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rb[j] = mod3(6'(s1_trow) * 6'd2 + 6'(j));
      cb[j] = mod3(6'(s1_tcol) * 6'd2 + 6'(j));
      rs[j] = RSW'(div3(6'(s1_trow) * 6'd2 + 6'(j)));
      cs[j] = CSW'(div3(6'(s1_tcol) * 6'd2 + 6'(j)));
    end
  end

  logic          s2_v;
  logic [PW-1:0] s2_uc, s2_vc, s2_lu, s2_lv;
  logic [1:0]    s2_rb [3];
  logic [1:0]    s2_cb [3];
  logic [BW-1:0] s2_addr [3][3];   // address per bank (row bank, col bank)
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s2_load <= 1'b0;
    end else begin
      s2_v <= s1_v;
      s2_load <= s1_load;
    end
    s2_uc <= s1_uc;
    s2_vc <= s1_vc;
    s2_lu <= s1_lu;
    s2_lv <= s1_lv;
    s2_lrt <= s1_lrt;
    s2_lct <= s1_lct;
    s2_waddr <= s1_waddr;
    s2_pt <= s1_pt;
    for (int j = 0; j < 3; j++) begin
      s2_rb[j] <= rb[j];
      s2_cb[j] <= cb[j];
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        s2_addr[rb[a]][cb[b]] <= BW'(int'(rs[a]) * COL_SLOTS + int'(cs[b]));
  end

  // Nine banks, one per (row tap, column tap), read in stage 3.
  bqpe_pkg::coord_vec_t rd [9];
  generate
    for (genvar g = 0; g < 9; g++) begin : g_bank
      bqpe_pkg::coord_vec_t mem [BANK_DEPTH];
      bqpe_pkg::coord_vec_t rd_q;
      always_ff @(posedge clk) begin
        if (s2_load && s2_lrt == 2'(g / 3) && s2_lct == 2'(g % 3))
          mem[s2_waddr] <= s2_pt;
        rd_q <= mem[s2_addr[g / 3][g % 3]];
      end
      assign rd[g] = rd_q;
    end
  endgenerate

  logic          s3_v;
  logic [PW-1:0] s3_uc, s3_vc, s3_lu, s3_lv;
  logic [1:0]    s3_rb [3];
  logic [1:0]    s3_cb [3];
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else s3_v <= s2_v;
    s3_uc <= s2_uc;
    s3_vc <= s2_vc;
    s3_lu <= s2_lu;
    s3_lv <= s2_lv;
    s3_rb <= s2_rb;
    s3_cb <= s2_cb;
  end

  // route the banks back to patch order
  bqpe_pkg::coord_t p [3][3][bqpe_pkg::CHANNELS];
  always_comb begin
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        for (int c = 0; c < bqpe_pkg::CHANNELS; c++)
          p[a][b][c] = rd[int'(s3_rb[a]) * 3 + int'(s3_cb[b])][c];
  end

  // Lerp pipeline: each lerp is diff/multiply (one stage) then round/add.
  // Values stay within 32-bit signed range since a lerp lies between ends.
  localparam int DW = 33;
  localparam int MW = DW + PW + 1;
  function automatic logic signed [MW-1:0] lmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [PW-1:0] t);
    logic signed [DW-1:0] d;
    d = DW'(b) - DW'(a);
    return MW'(d) * $signed({1'b0, t});
  endfunction
  function automatic logic signed [31:0] lfin(input logic signed [31:0] a,
                                              input logic signed [MW-1:0] m);
    logic signed [MW-1:0] q;
    q = (m + MW'(ONE / 2)) >>> FRAC_BITS;
    return 32'(MW'(a) + q);
  endfunction

  // stage 4: first-level row products (3 rows x 2 lerps x 5 ch)
  logic signed [MW-1:0] m4 [3][2][bqpe_pkg::CHANNELS];
  bqpe_pkg::coord_t a4 [3][2][bqpe_pkg::CHANNELS];
  logic s4_v, s5_v, s6_v, s7_v, s8_v, s9_v, s10_v;
  logic [PW-1:0] s4_lu, s5_lu;
  logic [PW-1:0] s4_lv, s5_lv, s6_lv, s7_lv, s8_lv, s9_lv;
  logic [PW-1:0] uc_d [7];
  logic [PW-1:0] vc_d [7];
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0; s5_v <= 1'b0; s6_v <= 1'b0; s7_v <= 1'b0;
      s8_v <= 1'b0; s9_v <= 1'b0; s10_v <= 1'b0;
    end else begin
      s4_v <= s3_v; s5_v <= s4_v; s6_v <= s5_v; s7_v <= s6_v;
      s8_v <= s7_v; s9_v <= s8_v; s10_v <= s9_v;
    end
    s4_lu <= s3_lu; s5_lu <= s4_lu;
    s4_lv <= s3_lv; s5_lv <= s4_lv; s6_lv <= s5_lv; s7_lv <= s6_lv;
    s8_lv <= s7_lv; s9_lv <= s8_lv;
    uc_d[0] <= s3_uc;
    vc_d[0] <= s3_vc;
    for (int k = 1; k < 7; k++) begin
      uc_d[k] <= uc_d[k-1];
      vc_d[k] <= vc_d[k-1];
    end
  end

  // row chain: stage4 mul, stage5 fin, stage6 mul, stage7 fin
  bqpe_pkg::coord_t r5 [3][2][bqpe_pkg::CHANNELS];
  logic signed [MW-1:0] m6 [3][bqpe_pkg::CHANNELS];
  bqpe_pkg::coord_t a6 [3][bqpe_pkg::CHANNELS];
  bqpe_pkg::coord_t r7 [3][bqpe_pkg::CHANNELS];
  logic signed [MW-1:0] m8 [2][bqpe_pkg::CHANNELS];
  bqpe_pkg::coord_t a8 [2][bqpe_pkg::CHANNELS];
  bqpe_pkg::coord_t c9 [2][bqpe_pkg::CHANNELS];
  logic signed [MW-1:0] m10 [bqpe_pkg::CHANNELS];
  bqpe_pkg::coord_t a10 [bqpe_pkg::CHANNELS];
  always_ff @(posedge clk) begin
    for (int c = 0; c < bqpe_pkg::CHANNELS; c++) begin
      for (int r = 0; r < 3; r++) begin
        for (int h = 0; h < 2; h++) begin
          m4[r][h][c] <= lmul(p[r][h][c], p[r][h+1][c], s3_lu);
          a4[r][h][c] <= p[r][h][c];
          r5[r][h][c] <= lfin(a4[r][h][c], m4[r][h][c]);
        end
        m6[r][c] <= lmul(r5[r][0][c], r5[r][1][c], s5_lu);
        a6[r][c] <= r5[r][0][c];
        r7[r][c] <= lfin(a6[r][c], m6[r][c]);
      end
      for (int h = 0; h < 2; h++) begin
        m8[h][c] <= lmul(r7[h][c], r7[h+1][c], s7_lv);
        a8[h][c] <= r7[h][c];
        c9[h][c] <= lfin(a8[h][c], m8[h][c]);
      end
      m10[c] <= lmul(c9[0][c], c9[1][c], s9_lv);
      a10[c] <= c9[0][c];
    end
  end

  // final rounding into the output register
  bqpe_pkg::coord_t res [bqpe_pkg::CHANNELS];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s10_v;
    for (int c = 0; c < bqpe_pkg::CHANNELS; c++)
      res[c] <= lfin(a10[c], m10[c]);
    sample_u <= 17'(uc_d[6]);
    sample_v <= 17'(vc_d[6]);
  end
  assign surf_x = res[0];
  assign surf_y = res[1];
  assign surf_z = res[2];
  assign surf_s = res[3];
  assign surf_t = res[4];
endmodule
